// ----- sv/wcir_pkg.sv -----
// ----------------------------------------------------------------------------
// wcir_pkg
// Shared widths, codes and constants for the wavetable cubic reader.
// ----------------------------------------------------------------------------
package wcir_pkg;

	localparam int TABLE_DEPTH   = 4096;
	localparam int IDX_W         = 12;
	localparam int LEN_W         = 13;
	localparam int SAMPLE_W      = 16;
	localparam int POS_W         = 29;
	localparam int FRACTION_BITS = 16;

	// four banks, interleaved on the low index bits
	localparam int BANKS       = 4;
	localparam int BANK_SEL_W  = 2;
	localparam int BANK_DEPTH  = TABLE_DEPTH / BANKS;
	localparam int BANK_AW     = IDX_W - BANK_SEL_W;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 29;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_OFFSET = 1'd1;

	// transaction modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [BANK_AW-1:0]         bank_addr_t;

endpackage

// ----- sv/wcir_ram.sv -----
// ----------------------------------------------------------------------------
// wcir_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while rd_en is low.
// ----------------------------------------------------------------------------
module wcir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/wavetable_cubic_interpolating_reader.sv -----
// ----------------------------------------------------------------------------
// wavetable_cubic_interpolating_reader
// Sample table with four-point cubic (Lagrange) interpolated read-out.
// ----------------------------------------------------------------------------
// The item channel carries two kinds of transaction. mode = write stores
// entry_value at entry_index and gives no result. mode = read adds the
// position_offset register to position (16 fraction bits), fetches the four
// neighbouring entries and returns one rounded, saturated Q1.15 sample on
// the result channel. Results come out in the order the reads went in.
// Throughput is one transaction per cycle while item_stall is low; a read's
// result comes from the registered output of the last pipeline stage.
// The table sits in four interleaved banks so
// all four neighbours come out of one RAM read. Writes land in stage 2, the
// same place reads fetch, so a read always sees every earlier write.
// Reset clears the pipeline and both config registers; table contents are
// undefined until written. When result_stall is high the result holds and
// upstream stages keep filling empty slots; item_stall rises only once every
// stage is occupied. Config may only be written while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module wavetable_cubic_interpolating_reader
	import wcir_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_enable,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   mode,
	input  logic [IDX_W-1:0]       entry_index,
	input  logic signed [SAMPLE_W-1:0] entry_value,
	input  logic signed [POS_W-1:0] position,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic signed [SAMPLE_W-1:0] sample_out
);

	localparam int STAGES   = 10;
	localparam int PSUM_W   = POS_W + 1;
	localparam int IP_W     = POS_W - FRACTION_BITS;
	localparam int T_W      = 17;
	localparam int CMB_W    = SAMPLE_W + 1;
	localparam int A_W      = 20;
	localparam int P_W      = 38;
	localparam int PLO_W    = 18;
	localparam int UP_W     = 56;
	localparam int IN_W     = 40;
	localparam int ILO_W    = 20;
	localparam int TOT_W    = 60;
	localparam int Q_W      = 28;
	localparam int QO_W     = 18;
	localparam int RCP_W    = 19;
	localparam int RCP_SH   = 20;
	localparam logic [T_W-1:0]   T_ONE     = T_W'(1 << FRACTION_BITS);
	localparam logic signed [Q_W-1:0] SAT_SPAN = Q_W'(3 * 32768);
	localparam logic signed [Q_W-1:0] Q_HIGH   = Q_W'(3 * 32768 - 1);
	localparam logic signed [Q_W-1:0] Q_LOW    = -Q_W'(3 * 32768);
	localparam logic [QO_W-1:0]  QO_MAX    = QO_W'(6 * 32768 - 1);
	// ceil(2^20 / 3): exact floor division by three for 18-bit values
	localparam logic [RCP_W-1:0] RECIP3    = RCP_W'(349526);

	// ---------------- configuration ----------------
	logic [LEN_W-1:0]          table_length_q;
	logic signed [POS_W-1:0]   position_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q    <= '0;
			position_offset_q <= '0;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				REG_TABLE_LENGTH:    table_length_q    <= cfg_data[LEN_W-1:0];
				REG_POSITION_OFFSET: position_offset_q <= $signed(cfg_data[POS_W-1:0]);
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0] len_eff;
	logic             len_short;
	logic [IDX_W-1:0] max_idx;

	always_comb begin
		len_eff   = (table_length_q > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
		                                                   : table_length_q;
		len_short = len_eff < LEN_W'(4);
		max_idx   = IDX_W'(len_eff - LEN_W'(3));
	end

	// ---------------- flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [STAGES:1] vld;
	logic [STAGES:1] adv;
	logic            mode_s2;

	assign vld = {v_s10, v_s9, v_s8, v_s7, v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};

	// a stage loads when it is empty or its content moves on
	always_comb begin
		adv[STAGES] = !vld[STAGES] || !result_stall;
		for (int k = STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign item_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else begin
			if (adv[1])  v_s1  <= item_valid;
			if (adv[2])  v_s2  <= v_s1;
			// write transactions retire once they reach the RAM
			if (adv[3])  v_s3  <= v_s2 && (mode_s2 == MODE_READ);
			if (adv[4])  v_s4  <= v_s3;
			if (adv[5])  v_s5  <= v_s4;
			if (adv[6])  v_s6  <= v_s5;
			if (adv[7])  v_s7  <= v_s6;
			if (adv[8])  v_s8  <= v_s7;
			if (adv[9])  v_s9  <= v_s8;
			if (adv[10]) v_s10 <= v_s9;
		end
	end

	// ---------------- stage 1: position sum ----------------
	logic                     mode_s1;
	logic [IDX_W-1:0]         eidx_s1;
	sample_t                  eval_s1;
	logic signed [PSUM_W-1:0] pos_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mode_s1 <= mode;
			eidx_s1 <= entry_index;
			eval_s1 <= entry_value;
			pos_s1  <= PSUM_W'(position) + PSUM_W'(position_offset_q);
		end
	end

	// ---------------- stage 2: clamp, fraction, bank addresses ----------------
	logic [IP_W-1:0]       ip;
	logic                  p_low;
	logic [IDX_W-1:0]      idx;
	logic [T_W-1:0]        t_frac;
	logic [IDX_W-1:0]      base_idx;
	logic [BANK_SEL_W-1:0] lane_off [BANKS];
	logic [IDX_W-1:0]      lane_idx [BANKS];

	always_comb begin
		ip    = pos_s1[PSUM_W-2:FRACTION_BITS];
		p_low = pos_s1[PSUM_W-1] || (ip == '0);
		if (p_low) begin
			idx    = IDX_W'(1);
			t_frac = '0;
		end else if (ip > IP_W'(max_idx)) begin
			idx    = max_idx;
			t_frac = T_ONE;
		end else begin
			idx    = ip[IDX_W-1:0];
			t_frac = T_W'(pos_s1[FRACTION_BITS-1:0]);
		end
		base_idx = idx - IDX_W'(1);
		// bank j holds whichever of the four neighbours has low bits j
		for (int j = 0; j < BANKS; j++) begin
			lane_off[j] = BANK_SEL_W'(j) - base_idx[BANK_SEL_W-1:0];
			lane_idx[j] = base_idx + IDX_W'(lane_off[j]);
		end
	end

	logic [IDX_W-1:0]      eidx_s2;
	sample_t               eval_s2;
	bank_addr_t            rd_addr_s2 [BANKS];
	logic [BANK_SEL_W-1:0] rot_s2;
	logic [T_W-1:0]        t_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mode_s2 <= mode_s1;
			eidx_s2 <= eidx_s1;
			eval_s2 <= eval_s1;
			rot_s2  <= base_idx[BANK_SEL_W-1:0];
			t_s2    <= t_frac;
			for (int j = 0; j < BANKS; j++) begin
				rd_addr_s2[j] <= lane_idx[j][IDX_W-1:BANK_SEL_W];
			end
		end
	end

	// ---------------- stage 3: table banks ----------------
	logic    wr_fire;
	sample_t bank_q [BANKS];

	assign wr_fire = v_s2 && (mode_s2 == MODE_WRITE) && adv[3];

	for (genvar j = 0; j < BANKS; j++) begin : g_bank
		wcir_ram #(
			.WIDTH (SAMPLE_W),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk     (clk),
			.wr_en   (wr_fire && (eidx_s2[BANK_SEL_W-1:0] == BANK_SEL_W'(j))),
			.wr_addr (eidx_s2[IDX_W-1:BANK_SEL_W]),
			.wr_data (eval_s2),
			.rd_en   (adv[3]),
			.rd_addr (rd_addr_s2[j]),
			.rd_data (bank_q[j])
		);
	end

	logic [BANK_SEL_W-1:0] rot_s3;
	logic [T_W-1:0]        t_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			rot_s3 <= rot_s2;
			t_s3   <= t_s2;
		end
	end

	// ---------------- stage 4: reorder, difference terms ----------------
	sample_t                 pa, pb, pc, pd;
	logic signed [CMB_W-1:0] cmb;
	logic signed [A_W-1:0]   cmb_w, a1, b1;

	always_comb begin
		case (rot_s3)
			2'd0:    begin pa = bank_q[0]; pb = bank_q[1]; pc = bank_q[2]; pd = bank_q[3]; end
			2'd1:    begin pa = bank_q[1]; pb = bank_q[2]; pc = bank_q[3]; pd = bank_q[0]; end
			2'd2:    begin pa = bank_q[2]; pb = bank_q[3]; pc = bank_q[0]; pd = bank_q[1]; end
			default: begin pa = bank_q[3]; pb = bank_q[0]; pc = bank_q[1]; pd = bank_q[2]; end
		endcase
		cmb   = CMB_W'(pc) - CMB_W'(pb);
		cmb_w = A_W'(cmb);
		a1    = A_W'(pd) - A_W'(pa) - ((cmb_w <<< 1) + cmb_w);
		b1    = A_W'(pd) + (A_W'(pa) <<< 1) - ((A_W'(pb) <<< 1) + A_W'(pb));
	end

	sample_t                 b_s4;
	logic signed [CMB_W-1:0] cmb_s4;
	logic signed [A_W-1:0]   a1_s4, b1_s4;
	logic [T_W-1:0]          t_s4, u_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			b_s4   <= pb;
			cmb_s4 <= cmb;
			a1_s4  <= a1;
			b1_s4  <= b1;
			t_s4   <= t_s3;
			u_s4   <= T_ONE - t_s3;
		end
	end

	// ---------------- stage 5: P = a1*t + b1*2^16 ----------------
	logic signed [T_W:0]   t_sx4;
	logic signed [P_W-1:0] p_prod;

	always_comb begin
		t_sx4  = $signed({1'b0, t_s4});
		p_prod = a1_s4 * t_sx4;
	end

	sample_t                 b_s5;
	logic signed [CMB_W-1:0] cmb_s5;
	logic signed [P_W-1:0]   p_s5;
	logic [T_W-1:0]          t_s5, u_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			b_s5   <= b_s4;
			cmb_s5 <= cmb_s4;
			p_s5   <= p_prod + (P_W'(b1_s4) <<< FRACTION_BITS);
			t_s5   <= t_s4;
			u_s5   <= u_s4;
		end
	end

	// ---------------- stage 6: u*P in two partial products ----------------
	logic signed [T_W:0]         u_sx5;
	logic signed [P_W-PLO_W-1:0] p_hi;
	logic signed [P_W-1:0]       up_hi;
	logic [T_W+PLO_W-1:0]        up_lo;

	always_comb begin
		u_sx5 = $signed({1'b0, u_s5});
		p_hi  = p_s5[P_W-1:PLO_W];
		up_hi = u_sx5 * p_hi;
		up_lo = u_s5 * p_s5[PLO_W-1:0];
	end

	sample_t                 b_s6;
	logic signed [CMB_W-1:0] cmb_s6;
	logic signed [P_W-1:0]   up_hi_s6;
	logic [T_W+PLO_W-1:0]    up_lo_s6;
	logic [T_W-1:0]          t_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			b_s6     <= b_s5;
			cmb_s6   <= cmb_s5;
			up_hi_s6 <= up_hi;
			up_lo_s6 <= up_lo;
			t_s6     <= t_s5;
		end
	end

	// ---------------- stage 7: inner = floor((6*cmb*2^32 - u*P) / 2^16) ----------------
	logic signed [UP_W-1:0] up_sum, cmb_x, diff;

	always_comb begin
		up_sum = (UP_W'(up_hi_s6) <<< PLO_W) + $signed(UP_W'(up_lo_s6));
		cmb_x  = UP_W'(cmb_s6);
		diff   = (cmb_x <<< 34) + (cmb_x <<< 33) - up_sum;
	end

	sample_t                b_s7;
	logic signed [IN_W-1:0] inner_s7;
	logic [T_W-1:0]         t_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			b_s7     <= b_s6;
			inner_s7 <= diff[UP_W-1:UP_W-IN_W];
			t_s7     <= t_s6;
		end
	end

	// ---------------- stage 8: t*inner in two partial products ----------------
	logic signed [T_W:0]         t_sx7;
	logic signed [IN_W-ILO_W-1:0] in_hi;
	logic signed [P_W-1:0]       ti_hi;
	logic [T_W+ILO_W-1:0]        ti_lo;

	always_comb begin
		t_sx7 = $signed({1'b0, t_s7});
		in_hi = inner_s7[IN_W-1:ILO_W];
		ti_hi = t_sx7 * in_hi;
		ti_lo = t_s7 * inner_s7[ILO_W-1:0];
	end

	sample_t               b_s8;
	logic signed [P_W-1:0] ti_hi_s8;
	logic [T_W+ILO_W-1:0]  ti_lo_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			b_s8     <= b_s7;
			ti_hi_s8 <= ti_hi;
			ti_lo_s8 <= ti_lo;
		end
	end

	// ---------------- stage 9: total, /2^33 with rounding, clamp ----------------
	logic signed [TOT_W-1:0] b_x, total;
	logic signed [Q_W-1:0]   q1;
	logic [QO_W-1:0]         qoff;

	always_comb begin
		b_x   = TOT_W'(b_s8);
		total = (b_x <<< 34) + (b_x <<< 33) + (TOT_W'(ti_hi_s8) <<< ILO_W)
		      + $signed(TOT_W'(ti_lo_s8)) + (TOT_W'(3) <<< 32);
		// floor(total / 2^33); the remaining divide by three gives /(6*2^32)
		q1    = {total[TOT_W-1], total[TOT_W-1:33]};
		// bias by 3*32768 so the divide by three works on a non-negative value
		if (q1 > Q_HIGH) begin
			qoff = QO_MAX;
		end else if (q1 < Q_LOW) begin
			qoff = '0;
		end else begin
			qoff = QO_W'(q1 + SAT_SPAN);
		end
	end

	logic [QO_W-1:0] qoff_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			qoff_s9 <= qoff;
		end
	end

	// ---------------- stage 10: divide by three, output register ----------------
	logic [QO_W+RCP_W-1:0] q3_prod;
	logic [SAMPLE_W-1:0]   q3;

	always_comb begin
		q3_prod = qoff_s9 * RECIP3;
		q3      = q3_prod[RCP_SH+SAMPLE_W-1:RCP_SH];
	end

	sample_t sample_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			// q3 - 32768 is a flip of the top bit
			sample_s10 <= len_short ? '0 : $signed({~q3[SAMPLE_W-1], q3[SAMPLE_W-2:0]});
		end
	end

	assign result_valid = v_s10;
	assign sample_out   = sample_s10;

endmodule

// ----- tb/sv/wcir_sample_checker.sv -----
// ----------------------------------------------------------------------------
// wcir_sample_checker
// Watches the wavetable reader's ports, predicts every read and compares.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the sample table and of both config
// registers. Each accepted write transaction updates the copy. Each accepted
// read transaction queues one predicted sample. Accepted results are checked
// in order against that queue.
// ----------------------------------------------------------------------------
module wcir_sample_checker
	import wcir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_enable,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  logic                       mode,
	input  logic [IDX_W-1:0]           entry_index,
	input  logic signed [SAMPLE_W-1:0] entry_value,
	input  logic signed [POS_W-1:0]    position,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic signed [SAMPLE_W-1:0] sample_out,
	output int                         pending,
	output int                         faults
);
	timeunit 1ns;
	timeprecision 1ps;

	sample_t                    sample_mem [TABLE_DEPTH];
	sample_t                    expected_samples [$];
	sample_t                    want;
	logic [LEN_W-1:0]           table_len;
	logic signed [POS_W-1:0]    read_offset;

	initial begin
		faults = 0;
		pending = 0;
	end

	task automatic note_fault(input string what);
		$display("ERROR @ %0t ns: %s", $time, what);
		faults++;
	endtask

	// floor division, as C division truncates towards zero
	function automatic longint div_floor(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q--;
		return q;
	endfunction

	function automatic sample_t interpolate(input logic signed [POS_W-1:0] pos);
		longint one_q32, p, ip, a, b, c, d, cmb, t, u, poly, inner, total, r;
		int span, idx;
		one_q32 = longint'(1) << 32;
		span = (table_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_len);
		if (span < 4)
			return '0;
		p = longint'(pos) + longint'(read_offset);
		if (p < (longint'(1) << FRACTION_BITS)) begin
			idx = 1;
			t = 0;
		end else begin
			ip = p >>> FRACTION_BITS;
			if (ip > span - 3) begin
				idx = span - 3;
				t = 65536;
			end else begin
				idx = int'(ip);
				t = p & ((longint'(1) << FRACTION_BITS) - 1);
				// bring the fraction to 16 bits
				if (FRACTION_BITS >= 16)
					t = t >>> (FRACTION_BITS - 16);
				else
					t = t <<< (16 - FRACTION_BITS);
			end
		end
		a = longint'(sample_mem[idx - 1]);
		b = longint'(sample_mem[idx]);
		c = longint'(sample_mem[idx + 1]);
		d = longint'(sample_mem[idx + 2]);
		cmb = c - b;
		u = 65536 - t;
		poly = (d - a - 3 * cmb) * t + (d + 2 * a - 3 * b) * 65536;
		inner = div_floor(6 * cmb * one_q32 - u * poly, 65536);
		total = 6 * b * one_q32 + t * inner;
		r = div_floor(total + 3 * one_q32, 6 * one_q32);
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return sample_t'(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_samples.delete();
			table_len = '0;
			read_offset = '0;
			pending = 0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					REG_TABLE_LENGTH:    table_len = cfg_data[LEN_W-1:0];
					REG_POSITION_OFFSET: read_offset = cfg_data;
					default: ;
				endcase
			end
			// results first: a read never comes out at the edge it goes in
			if (result_valid && !result_stall) begin
				if (expected_samples.size() == 0) begin
					note_fault($sformatf("sample_out %0d with no read outstanding",
						sample_out));
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want)
						note_fault($sformatf("sample_out %0d, expected %0d",
							sample_out, want));
				end
			end
			if (item_valid && !item_stall) begin
				if (mode == MODE_WRITE)
					sample_mem[entry_index] = entry_value;
				else
					expected_samples.push_back(interpolate(position));
			end
			pending = expected_samples.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the wavetable cubic interpolating reader.
// ----------------------------------------------------------------------------
// A directed run covers short tables, clamping at both ends of the table,
// extreme samples and offsets. Random phases follow, each with its own table
// length and offset: mostly reads aimed in and around the table, plus writes
// and reads at arbitrary positions. Entries are always written before any
// read can touch them. Both channels idle in random bursts, except in the
// last phase. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top
	import wcir_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 5;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 110;
	localparam int SETTLE       = 16;
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write_enable;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       item_valid;
	logic                       item_stall;
	logic                       mode;
	logic [IDX_W-1:0]           entry_index;
	logic signed [SAMPLE_W-1:0] entry_value;
	logic signed [POS_W-1:0]    position;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [SAMPLE_W-1:0] sample_out;
	int                         pending;
	int                         faults;

	int                         cycles;
	int                         stall_run;
	bit                         calm;
	bit                         filled [TABLE_DEPTH];
	int                         cur_len;
	logic signed [POS_W-1:0]    cur_off;

	wavetable_cubic_interpolating_reader dut (.*);
	wcir_sample_checker checker_i (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("** wavetable_cubic_interpolating_reader: FAILED **");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	always @(negedge clk) begin
		if (calm) begin
			result_stall <= 1'b0;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else if (!result_stall && $urandom_range(0, 1) == 1) begin
			result_stall <= 1'b1;
			stall_run <= $urandom_range(0, 15);
		end else begin
			result_stall <= 1'b0;
			stall_run <= $urandom_range(0, 30);
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0:       return sample_t'(16'sh7fff);
			1:       return sample_t'(16'sh8000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// lowest entry a read at pos will touch, or -1 when the table is too short
	function automatic int window_base(input logic signed [POS_W-1:0] pos);
		int span;
		longint p, ip;
		span = (cur_len > TABLE_DEPTH) ? TABLE_DEPTH : cur_len;
		if (span < 4)
			return -1;
		p = longint'(pos) + longint'(cur_off);
		if (p < (longint'(1) << FRACTION_BITS))
			return 0;
		ip = p >>> FRACTION_BITS;
		return (ip > span - 3) ? span - 4 : int'(ip) - 1;
	endfunction

	task automatic put_item(input logic m, input logic [IDX_W-1:0] ei, input sample_t ev,
			input logic signed [POS_W-1:0] pos);
		item_valid <= 1'b1;
		mode <= m;
		entry_index <= ei;
		entry_value <= ev;
		position <= pos;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_entry(input logic [IDX_W-1:0] idx, input sample_t val);
		put_item(MODE_WRITE, idx, val, POS_W'($urandom));
		filled[idx] = 1'b1;
	endtask

	task automatic read_at(input logic signed [POS_W-1:0] pos);
		int base;
		base = window_base(pos);
		if (base >= 0)
			for (int k = base; k < base + 4; k++)
				if (!filled[k])
					write_entry(IDX_W'(k), pick_sample());
		put_item(MODE_READ, IDX_W'($urandom), sample_t'($urandom), pos);
	endtask

	task automatic pause_maybe();
		if (!calm && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(negedge clk);
		end
	endtask

	// writes give no result, so give the pipe time to empty after the last read
	task automatic drain(input int settle);
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (settle)
			@(negedge clk);
	endtask

	task automatic set_config(input int len, input logic signed [POS_W-1:0] off);
		drain(SETTLE);
		cfg_write_enable <= 1'b1;
		cfg_index <= REG_TABLE_LENGTH;
		cfg_data <= CFG_DATA_W'(len);
		@(negedge clk);
		cfg_index <= REG_POSITION_OFFSET;
		cfg_data <= off;
		@(negedge clk);
		cfg_write_enable <= 1'b0;
		cur_len = len;
		cur_off = off;
	endtask

	task automatic random_item();
		int span, pick;
		longint target, pos;
		span = (cur_len > TABLE_DEPTH) ? TABLE_DEPTH : cur_len;
		pick = $urandom_range(0, 99);
		if (pick < 60 && span >= 4) begin
			// aim just below the table start up to just past its end
			target = longint'($urandom_range(0, (span + 1) << 16)) - 65536;
			pos = target - longint'(cur_off);
			if (pos >= longint'(POS_MIN) && pos <= longint'(POS_MAX))
				read_at(POS_W'(pos));
			else
				read_at(POS_W'($urandom));
		end else if (pick < 80) begin
			write_entry(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_sample());
		end else begin
			read_at(POS_W'($urandom));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_enable = 1'b0;
		cfg_index = REG_TABLE_LENGTH;
		cfg_data = '0;
		item_valid = 1'b0;
		mode = MODE_WRITE;
		entry_index = '0;
		entry_value = '0;
		position = '0;
		result_stall = 1'b0;
		stall_run = 0;
		cycles = 0;
		calm = 1'b0;
		cur_len = 0;
		cur_off = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table straight after reset, then one too short
		read_at('0);
		read_at(POS_MAX);
		set_config(3, '0);
		read_at(POS_W'(1 << 16));

		// smallest usable table, full-swing samples
		set_config(4, '0);
		write_entry(0, sample_t'(16'sh7fff));
		write_entry(1, sample_t'(16'sh8000));
		write_entry(2, sample_t'(16'sh7fff));
		write_entry(3, sample_t'(16'sh8000));
		read_at('0);
		read_at(POS_W'(1 << 16));
		read_at(POS_W'((1 << 16) | 16'h8000));
		read_at(POS_W'((1 << 16) | 16'hffff));
		read_at(POS_W'(2 << 16));
		read_at(POS_MAX);
		read_at(POS_MIN);
		write_entry(IDX_W'(TABLE_DEPTH - 1), sample_t'(16'sh7fff));

		// full table with the offset at both extremes
		set_config(TABLE_DEPTH, POS_MAX);
		read_at(POS_MIN);
		read_at(POS_MAX);
		set_config(TABLE_DEPTH, POS_MIN);
		read_at(POS_MAX);
		read_at(POS_W'(-(1 << 16)));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(TABLE_DEPTH, '0);
				1: set_config(4, '0);
				2: set_config($urandom_range(5, 64),
					POS_W'(int'($urandom_range(0, 8 << 16)) - (4 << 16)));
				3: set_config($urandom_range(0, 3), POS_W'($urandom));
				4: set_config(TABLE_DEPTH, POS_MAX);
				5: set_config($urandom_range(4, TABLE_DEPTH), POS_MIN);
				6: set_config($urandom_range(4, 300), POS_W'($urandom));
				default: set_config($urandom_range(64, TABLE_DEPTH), '0);
			endcase
			calm = (ph == 7);
			repeat (PHASE_ITEMS) begin
				random_item();
				pause_maybe();
			end
		end

		drain(SETTLE + 4);
		if (faults == 0)
			$display("** wavetable_cubic_interpolating_reader: PASSED **");
		else
			$display("** wavetable_cubic_interpolating_reader: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
sv/wcir_pkg.sv
sv/wcir_ram.sv
sv/wavetable_cubic_interpolating_reader.sv
tb/sv/wcir_sample_checker.sv
tb/sv/tb_top.sv
